FILE: rtl/wlmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wlmp_pkg;

    // Field widths of the transaction payloads
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 6;
    localparam int WL_W    = 15;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 16;
    localparam int BYTE_W  = 8;

    // Defaults for the top level parameters
    localparam int TABLE_DEPTH_DEF  = 64;
    localparam int WL_FRAC_BITS_DEF = 4;

    // Wavelength grid spacing in nm, kept as odd factor and power of two
    localparam int GRID_ODD       = 25;
    localparam int GRID_ODD_SHIFT = 1;
    localparam int GRID_NM        = GRID_ODD << GRID_ODD_SHIFT;

    // Quotient digit width of the grid step divider
    localparam int DIV_CHUNK = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SETWL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPEED = 2'd2;

    // Frame layout
    localparam int                FRAME_LEN  = 10;
    localparam logic [3:0]        LAST_BYTE  = 4'(FRAME_LEN - 1);
    localparam logic [BYTE_W-1:0] HDR_B0     = 8'h08;
    localparam logic [BYTE_W-1:0] HDR_B1     = 8'h0F;
    localparam logic [BYTE_W-1:0] HDR_B2     = 8'hF0;
    localparam logic [BYTE_W-1:0] HDR_B3     = 8'h24;
    localparam logic [BYTE_W-1:0] OP_POSITION = 8'h9E;
    localparam logic [BYTE_W-1:0] OP_SPEED    = 8'hA0;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GDIV,
        ST_GRID,
        ST_SCAN,
        ST_MULA,
        ST_MULB,
        ST_ADD,
        ST_ABS,
        ST_QDIV,
        ST_FIX,
        ST_EMIT
    } wlmp_state_t;

    // Control of the shared divider
    typedef struct packed {
        logic load;
        logic step;
    } wlmp_div_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/wavelength_to_motor_position_frame_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Wavelength to motor position frame builder. Three commands arrive as input
// transactions: a load writes one calibration entry (wavelength, position) into
// the table and produces no output; a set-speed emits a 10-byte speed frame; a
// set-wavelength finds the 50 nm grid points around the target (last matching
// table entry wins), interpolates linearly with truncation toward zero and
// emits a 10-byte position frame, one byte per output transaction, with
// not_found set on every byte if a needed grid point was missing (it counts
// as position 0). The block takes one command at a time and is not ready
// until the frame's last byte has been taken. A load leaves the block ready;
// a speed command goes straight to its bytes. A set-wavelength passes the
// accept, 5 divider steps for the target modulo the grid step, the grid
// points and the table scan, then the 10 bytes when the target lies on the
// grid; between grid points it adds two multiplies, the add, the sign split,
// 5 more divider steps and the fix-up before the bytes. The table scan reads
// one entry per cycle through the table memory's read port; the shared divider
// by the grid step handles one 8-bit digit per cycle. Only table slots 0 to
// min(TABLE_DEPTH,64)-1 can be loaded; valid bits clear at reset.
module wavelength_to_motor_position_frame_top import wlmp_pkg::*; #(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int WL_FRAC_BITS = WL_FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [CMD_W-1:0]          cmd,
    input  wire logic [IDX_W-1:0]          entry_index,
    input  wire logic [WL_W-1:0]           entry_wavelength,
    input  wire logic signed [POS_W-1:0]   entry_position,
    input  wire logic [WL_W-1:0]           target_wavelength,
    input  wire logic [SPEED_W-1:0]        speed_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [BYTE_W-1:0]              frame_byte,
    output logic                           frame_last,
    output logic                           not_found
);

    // Derived sizes
    localparam int EFF_DEPTH = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
    localparam int ADDR_W    = $clog2(EFF_DEPTH);
    localparam int GRID_STEP = GRID_NM << WL_FRAC_BITS;
    localparam int G_W       = $clog2(GRID_STEP + 1);
    localparam int NUM_W     = POS_W + G_W + 2;
    localparam int MAG_W     = NUM_W - 1;
    localparam int CNT_W     = $clog2(MAG_W + 1);
    localparam int ENT_W     = WL_W + POS_W;
    localparam int EWL_W     = WL_W + 1;
    localparam int DIV_SHIFT = WL_FRAC_BITS + GRID_ODD_SHIFT;
    localparam int DIV_STEPS = (MAG_W - DIV_SHIFT + DIV_CHUNK - 1) / DIV_CHUNK;

    localparam logic [EWL_W-1:0] GRID_X    = EWL_W'(GRID_STEP);
    localparam logic [G_W:0]     GRID_MUL  = (G_W + 1)'(GRID_STEP);
    localparam logic [ADDR_W:0]  DEPTH_X   = (ADDR_W + 1)'(EFF_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_IDX = (IDX_W + 1)'(EFF_DEPTH);

    // Control state
    wlmp_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     step_cnt_reg, step_cnt_next;
    logic [ADDR_W:0]      scan_cnt_reg, scan_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [3:0]           byte_cnt_reg, byte_cnt_next;
    logic [EFF_DEPTH-1:0] valid_reg, valid_next;

    // Datapath
    logic [WL_W-1:0]           t_reg, t_next;
    logic [G_W-1:0]            rem_reg, rem_next;
    logic [EWL_W-1:0]          wf_reg, wf_next;
    logic [EWL_W-1:0]          ceil_reg, ceil_next;
    logic signed [POS_W-1:0]   pf_reg, pf_next;
    logic signed [POS_W-1:0]   pc_reg, pc_next;
    logic                      hit_f_reg, hit_f_next;
    logic                      hit_c_reg, hit_c_next;
    logic signed [POS_W:0]     diff_reg, diff_next;
    logic signed [NUM_W-1:0]   prod_reg, prod_next;
    logic signed [NUM_W-1:0]   acc_reg, acc_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic                      neg_reg, neg_next;
    logic [POS_W-1:0]          word_reg, word_next;
    logic                      spd_reg, spd_next;
    logic                      nf_reg, nf_next;
    logic [BYTE_W-1:0]         sum_reg, sum_next;

    // Shared multiplier operands
    logic signed [POS_W:0]     mul_a;
    logic signed [G_W:0]       mul_b;
    logic signed [NUM_W-1:0]   mul_p;

    // Table memory and divider hookup
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [ENT_W-1:0]          mem_rdata;
    logic [WL_W-1:0]           rd_wl;
    logic signed [POS_W-1:0]   rd_pos;
    wlmp_div_ctrl_t            div_ctrl;
    logic [MAG_W-1:0]          div_dividend;
    logic [MAG_W-1:0]          div_quo;
    logic [G_W-1:0]            div_rem;

    logic                      scan_issue;
    logic                      rd_valid;
    logic [NUM_W-1:0]          num_abs;
    logic                      ovf_pos;
    logic                      ovf_neg;
    logic [EWL_W-1:0]          wf_calc;

    wlmp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (EFF_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (entry_index[ADDR_W-1:0]),
        .wdata ({entry_wavelength, entry_position}),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    wlmp_div #(
        .MAG_W (MAG_W),
        .ODD   (GRID_ODD),
        .SHIFT (DIV_SHIFT)
    ) u_div (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign rd_wl      = mem_rdata[POS_W +: WL_W];
    assign rd_pos     = signed'(mem_rdata[POS_W-1:0]);
    assign rd_valid   = rd_pend_reg && valid_reg[rd_idx_reg];
    assign scan_issue = (state_reg == ST_SCAN) && (scan_cnt_reg < DEPTH_X);
    assign mem_raddr  = scan_cnt_reg[ADDR_W-1:0];
    assign mul_p      = mul_a * mul_b;
    assign num_abs    = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign wf_calc    = EWL_W'(t_reg) - EWL_W'(div_rem);

    // Saturation of the signed quotient to 32 bits
    assign ovf_pos = !neg_reg && ((|div_quo[MAG_W-1:POS_W]) || div_quo[POS_W-1]);
    assign ovf_neg = neg_reg && ((|div_quo[MAG_W-1:POS_W])
                     || (div_quo[POS_W-1] && (|div_quo[POS_W-2:0])));

    // Handshake and output bytes
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);
    assign frame_last = (byte_cnt_reg == LAST_BYTE);
    assign not_found  = nf_reg;

    always_comb
    begin
        case (byte_cnt_reg)
            4'd0:    frame_byte = HDR_B0;
            4'd1:    frame_byte = HDR_B1;
            4'd2:    frame_byte = HDR_B2;
            4'd3:    frame_byte = HDR_B3;
            4'd4:    frame_byte = spd_reg ? OP_SPEED : OP_POSITION;
            4'd5:    frame_byte = word_reg[15:8];
            4'd6:    frame_byte = word_reg[7:0];
            4'd7:    frame_byte = word_reg[31:24];
            4'd8:    frame_byte = word_reg[23:16];
            default: frame_byte = sum_reg;
        endcase
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_pend_next  = scan_issue;
        rd_idx_next   = mem_raddr;
        byte_cnt_next = byte_cnt_reg;
        valid_next    = valid_reg;
        t_next        = t_reg;
        rem_next      = rem_reg;
        wf_next       = wf_reg;
        ceil_next     = ceil_reg;
        pf_next       = pf_reg;
        pc_next       = pc_reg;
        hit_f_next    = hit_f_reg;
        hit_c_next    = hit_c_reg;
        diff_next     = diff_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        num_next      = num_reg;
        neg_next      = neg_reg;
        word_next     = word_reg;
        spd_next      = spd_reg;
        nf_next       = nf_reg;
        sum_next      = sum_reg;
        mem_we        = 1'b0;
        div_ctrl      = '0;
        div_dividend  = MAG_W'(target_wavelength);
        mul_a         = {pf_reg[POS_W-1], pf_reg};
        mul_b         = GRID_MUL;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        if ({1'b0, entry_index} < DEPTH_IDX)
                        begin
                            mem_we = 1'b1;
                            valid_next[entry_index[ADDR_W-1:0]] = 1'b1;
                        end
                    end
                    else if (cmd == CMD_SETWL)
                    begin
                        t_next        = target_wavelength;
                        div_ctrl.load = 1'b1;
                        step_cnt_next = CNT_W'(DIV_STEPS - 1);
                        state_next    = ST_GDIV;
                    end
                    else if (cmd == CMD_SPEED)
                    begin
                        word_next     = {speed_value, 16'h0000};
                        spd_next      = 1'b1;
                        nf_next       = 1'b0;
                        byte_cnt_next = '0;
                        sum_next      = '0;
                        state_next    = ST_EMIT;
                    end
                end
            end

            // Target modulo grid step
            ST_GDIV:
            begin
                div_ctrl.step = 1'b1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == '0)
                begin
                    state_next = ST_GRID;
                end
            end

            // Floor and ceiling grid points
            ST_GRID:
            begin
                rem_next      = div_rem;
                wf_next       = wf_calc;
                ceil_next     = wf_calc + GRID_X;
                scan_cnt_next = '0;
                pf_next       = '0;
                pc_next       = '0;
                hit_f_next    = 1'b0;
                hit_c_next    = 1'b0;
                state_next    = ST_SCAN;
            end

            // One table entry per cycle; later matches overwrite earlier ones
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (rd_valid && ({1'b0, rd_wl} == wf_reg))
                begin
                    pf_next    = rd_pos;
                    hit_f_next = 1'b1;
                end
                if (rd_valid && ({1'b0, rd_wl} == ceil_reg))
                begin
                    pc_next    = rd_pos;
                    hit_c_next = 1'b1;
                end
                if (!scan_issue && !rd_pend_reg)
                begin
                    spd_next      = 1'b0;
                    byte_cnt_next = '0;
                    sum_next      = '0;
                    if (rem_reg == '0)
                    begin
                        nf_next    = !hit_f_reg;
                        word_next  = pf_reg;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        nf_next    = !hit_f_reg || !hit_c_reg;
                        state_next = ST_MULA;
                    end
                end
            end

            // pf * G, and the slope pc - pf
            ST_MULA:
            begin
                prod_next  = mul_p;
                diff_next  = {pc_reg[POS_W-1], pc_reg} - {pf_reg[POS_W-1], pf_reg};
                state_next = ST_MULB;
            end

            // rem * (pc - pf)
            ST_MULB:
            begin
                mul_a      = diff_reg;
                mul_b      = {1'b0, rem_reg};
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                num_next   = acc_reg + prod_reg;
                state_next = ST_ABS;
            end

            // Divide the magnitude, fix the sign afterwards
            ST_ABS:
            begin
                neg_next      = num_reg[NUM_W-1];
                div_dividend  = num_abs[MAG_W-1:0];
                div_ctrl.load = 1'b1;
                step_cnt_next = CNT_W'(DIV_STEPS - 1);
                state_next    = ST_QDIV;
            end

            ST_QDIV:
            begin
                div_ctrl.step = 1'b1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                if (ovf_pos)
                begin
                    word_next = {1'b0, {(POS_W - 1){1'b1}}};
                end
                else if (ovf_neg)
                begin
                    word_next = {1'b1, {(POS_W - 1){1'b0}}};
                end
                else if (neg_reg)
                begin
                    word_next = -div_quo[POS_W-1:0];
                end
                else
                begin
                    word_next = div_quo[POS_W-1:0];
                end
                state_next = ST_EMIT;
            end

            // One byte per output transaction, checksum accumulates
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    sum_next      = sum_reg + frame_byte;
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_reg == LAST_BYTE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_idx_reg   <= '0;
            byte_cnt_reg <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            rd_idx_reg   <= rd_idx_next;
            byte_cnt_reg <= byte_cnt_next;
            valid_reg    <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        rem_reg   <= rem_next;
        wf_reg    <= wf_next;
        ceil_reg  <= ceil_next;
        pf_reg    <= pf_next;
        pc_reg    <= pc_next;
        hit_f_reg <= hit_f_next;
        hit_c_reg <= hit_c_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        num_reg   <= num_next;
        neg_reg   <= neg_next;
        word_reg  <= word_next;
        spd_reg   <= spd_next;
        nf_reg    <= nf_next;
        sum_reg   <= sum_next;
    end

    // Checks
    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && frame_last |=> in_ready)
        else $error("block not idle after the last frame byte");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_LOAD) |=> in_ready && !out_valid)
        else $error("table load produced output or stalled");

    a_speed_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_SPEED) |=> out_valid && !not_found && !frame_last)
        else $error("speed frame did not start cleanly");

    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_cnt_reg <= LAST_BYTE)
        else $error("frame byte counter out of range");

endmodule

`default_nettype wire

FILE: rtl/wlmp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wlmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/wlmp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Divider by the constant ODD << SHIFT. The low SHIFT bits go straight to the
// remainder; the rest is divided by ODD one DIV_CHUNK-bit digit per step, each
// digit found by a reciprocal multiply on the partial remainder and the top chunk.
module wlmp_div import wlmp_pkg::*; #(
    parameter int MAG_W = 43,
    parameter int ODD   = 25,
    parameter int SHIFT = 5
) (
    input  wire logic                        clk,
    input  wire wlmp_div_ctrl_t              ctrl,
    input  wire logic [MAG_W-1:0]            dividend,
    output logic      [MAG_W-1:0]            quotient,
    output logic      [$clog2(ODD)+SHIFT-1:0] remainder
);

    localparam int CH_W  = DIV_CHUNK;
    localparam int ODD_W = $clog2(ODD);
    localparam int HI_W  = MAG_W - SHIFT;
    localparam int N_CH  = (HI_W + CH_W - 1) / CH_W;
    localparam int PAD_W = N_CH * CH_W;
    localparam int V_W   = ODD_W + CH_W;
    localparam int RCP_S = V_W + ODD_W;
    localparam longint RCP = ((longint'(1) << RCP_S) + ODD - 1) / ODD;
    localparam int RCP_W = RCP_S - ODD_W + 1;
    localparam int PR_W  = V_W + RCP_W;

    localparam logic [RCP_W-1:0] RCP_X = RCP_W'(RCP);
    localparam logic [ODD_W-1:0] ODD_X = ODD_W'(ODD);

    logic [SHIFT-1:0] low_reg, low_next;
    logic [PAD_W-1:0] hi_reg, hi_next;
    logic [PAD_W-1:0] quo_reg, quo_next;
    logic [ODD_W-1:0] rem_reg, rem_next;
    logic [V_W-1:0]   part;
    logic [PR_W-1:0]  prod;
    logic [CH_W-1:0]  digit;
    logic [V_W-1:0]   back;

    // Next digit: partial remainder and top chunk times the reciprocal
    always_comb
    begin
        part     = {rem_reg, hi_reg[PAD_W-1 -: CH_W]};
        prod     = PR_W'(part) * PR_W'(RCP_X);
        digit    = prod[RCP_S +: CH_W];
        back     = V_W'(digit) * V_W'(ODD_X);
        low_next = low_reg;
        hi_next  = hi_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (ctrl.load)
        begin
            low_next = dividend[SHIFT-1:0];
            hi_next  = PAD_W'(dividend[MAG_W-1:SHIFT]);
            quo_next = '0;
            rem_next = '0;
        end
        else if (ctrl.step)
        begin
            hi_next  = hi_reg << CH_W;
            quo_next = {quo_reg[PAD_W-CH_W-1:0], digit};
            rem_next = ODD_W'(part - back);
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg <= low_next;
        hi_reg  <= hi_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = MAG_W'(quo_reg);
    assign remainder = {rem_reg, low_reg};

endmodule

`default_nettype wire

FILE: tb/wavelength_to_motor_position_frame_top_test.sv
`timescale 1ns / 1ps

module wavelength_to_motor_position_frame_top_test;
    import wlmp_pkg::*;

    // Command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int GRID_STEP    = GRID_NM << WL_FRAC_BITS_DEF;
    localparam int GRID_TOP     = 40;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 200;
    localparam int SINK_HOLD    = 500;

    // One command with an optional typed-in expectation
    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [IDX_W-1:0]   slot;
        logic [WL_W-1:0]    cal_wl;
        logic [POS_W-1:0]   cal_pos;
        logic [WL_W-1:0]    target;
        logic [SPEED_W-1:0] speed;
        logic               typed;
        logic [POS_W-1:0]   exp_word;
        logic               exp_nf;
    } command_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              nf;
    } frame_byte_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          cmd = CMD_LOAD;
    logic [IDX_W-1:0]          entry_index = '0;
    logic [WL_W-1:0]           entry_wavelength = '0;
    logic signed [POS_W-1:0]   entry_position = '0;
    logic [WL_W-1:0]           target_wavelength = '0;
    logic [SPEED_W-1:0]        speed_value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [BYTE_W-1:0]         frame_byte;
    logic                      frame_last;
    logic                      not_found;

    // Shadow calibration table
    logic [WL_W-1:0]           shadow_wl [64];
    logic signed [POS_W-1:0]   shadow_pos [64];
    logic                      shadow_valid [64];

    frame_byte_t frame_bytes_due [$];

    int mismatch_count = 0;
    int accepted_count = 0;
    int bytes_checked = 0;
    int position_frames = 0;
    int missing_frames = 0;
    int speed_frames = 0;
    int cycle_count = 0;

    wavelength_to_motor_position_frame_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .entry_index       (entry_index),
        .entry_wavelength  (entry_wavelength),
        .entry_position    (entry_position),
        .target_wavelength (target_wavelength),
        .speed_value       (speed_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .frame_byte        (frame_byte),
        .frame_last        (frame_last),
        .not_found         (not_found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Position of one grid point; last valid matching slot wins
    function automatic longint grid_position(input int unsigned wl, inout bit missing);
        longint pos;
        bit     hit;
        pos = 0;
        hit = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            if (shadow_valid[i] && int'(shadow_wl[i]) == wl)
            begin
                pos = longint'(shadow_pos[i]);
                hit = 1'b1;
            end
        end
        if (!hit)
            missing = 1'b1;
        return pos;
    endfunction

    // Interpolated motor position, truncated toward zero and saturated
    function automatic logic [POS_W-1:0] target_position(input logic [WL_W-1:0] target,
                                                         output bit missing);
        int unsigned t;
        int unsigned rem;
        longint      lo;
        longint      hi;
        longint      p;
        t = target;
        rem = t % GRID_STEP;
        missing = 1'b0;
        if (rem == 0)
            p = grid_position(t, missing);
        else
        begin
            lo = grid_position(t - rem, missing);
            hi = grid_position(t - rem + GRID_STEP, missing);
            p = (lo * GRID_STEP + longint'(rem) * (hi - lo)) / GRID_STEP;
        end
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[POS_W-1:0];
    endfunction

    // Header, opcode, four payload bytes, checksum
    function automatic void queue_frame(input logic [BYTE_W-1:0] opcode,
                                        input logic [4*BYTE_W-1:0] payload, input bit nf);
        logic [BYTE_W-1:0] bytes [FRAME_LEN];
        logic [BYTE_W-1:0] sum;
        frame_byte_t       fb;
        bytes[0] = HDR_B0;
        bytes[1] = HDR_B1;
        bytes[2] = HDR_B2;
        bytes[3] = HDR_B3;
        bytes[4] = opcode;
        for (int k = 0; k < 4; k++)
            bytes[5 + k] = payload[(3 - k) * BYTE_W +: BYTE_W];
        sum = '0;
        for (int k = 0; k < FRAME_LEN - 1; k++)
            sum = sum + bytes[k];
        bytes[FRAME_LEN - 1] = sum;
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            fb.data = bytes[k];
            fb.last = (k == FRAME_LEN - 1);
            fb.nf = nf;
            frame_bytes_due.push_back(fb);
        end
    endfunction

    // Update the shadow table or queue the frame an accepted command causes
    function automatic void predict_command(input command_row_t c);
        logic [POS_W-1:0]   p;
        logic [SPEED_W-1:0] s;
        bit                 nf;
        case (c.op)
            CMD_LOAD:
            begin
                shadow_wl[c.slot] = c.cal_wl;
                shadow_pos[c.slot] = c.cal_pos;
                shadow_valid[c.slot] = 1'b1;
            end
            CMD_SETWL:
            begin
                p = target_position(c.target, nf);
                if (c.typed)
                begin
                    p = c.exp_word;
                    nf = c.exp_nf;
                end
                queue_frame(OP_POSITION, {p[15:8], p[7:0], p[31:24], p[23:16]}, nf);
                position_frames++;
                if (nf)
                    missing_frames++;
            end
            CMD_SPEED:
            begin
                s = c.typed ? c.exp_word[SPEED_W-1:0] : c.speed;
                queue_frame(OP_SPEED, {16'h0000, s}, 1'b0);
                speed_frames++;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic command_row_t make_row(input logic [CMD_W-1:0] op,
                                              input int slot, input int wl, input int pos,
                                              input int target, input int speed,
                                              input bit typed, input int word, input bit nf);
        command_row_t c;
        c.op = op;
        c.slot = IDX_W'(slot);
        c.cal_wl = WL_W'(wl);
        c.cal_pos = POS_W'(pos);
        c.target = WL_W'(target);
        c.speed = SPEED_W'(speed);
        c.typed = typed;
        c.exp_word = POS_W'(word);
        c.exp_nf = nf;
        return c;
    endfunction

    function automatic logic [POS_W-1:0] draw_position();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return POS_W'($urandom_range(0, 2000)) - 32'd1000;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Mostly grid loads and queries around the grid, some noise
    function automatic command_row_t draw_command();
        command_row_t c;
        int           pick;
        int           k;
        int           rem;
        c.slot = IDX_W'($urandom);
        c.cal_wl = WL_W'($urandom);
        c.cal_pos = POS_W'($urandom);
        c.target = WL_W'($urandom);
        c.speed = SPEED_W'($urandom);
        c.typed = 1'b0;
        c.exp_word = '0;
        c.exp_nf = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            c.op = CMD_LOAD;
            c.cal_wl = WL_W'($urandom_range(0, GRID_TOP) * GRID_STEP);
            c.cal_pos = draw_position();
        end
        else if (pick < 42)
        begin
            c.op = CMD_LOAD;
            c.cal_pos = draw_position();
        end
        else if (pick < 77)
        begin
            c.op = CMD_SETWL;
            if ($urandom_range(0, 4) != 0)
            begin
                k = $urandom_range(0, GRID_TOP);
                rem = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, GRID_STEP - 1);
                if (k * GRID_STEP + rem > 32767)
                    rem = rem % (32768 - k * GRID_STEP);
                c.target = WL_W'(k * GRID_STEP + rem);
            end
        end
        else if (pick < 93)
            c.op = CMD_SPEED;
        else
            c.op = CMD_UNUSED;
        return c;
    endfunction

    // Offer one command after a random gap and wait for its handshake
    task automatic offer_command(input command_row_t c);
        int gap;
        gap = (((accepted_count / 40) % 4) == 3) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c.op;
        entry_index <= c.slot;
        entry_wavelength <= c.cal_wl;
        entry_position <= c.cal_pos;
        target_wavelength <= c.target;
        speed_value <= c.speed;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accepted_count++;
        predict_command(c);
    endtask

    initial
    begin : command_source
        command_row_t directed [$];
        command_row_t c;
        int           random_items;
        bit           paused;

        random_items = 0;
        paused = 1'b0;
        for (int i = 0; i < 64; i++)
            shadow_valid[i] = 1'b0;

        // Directed: empty table, speed extremes, last match wins, gaps in the grid
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 0, 0, 1, 0, 1));
        directed.push_back(make_row(CMD_SPEED, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_row(CMD_SPEED, 0, 0, 0, 0, 65535, 1, 65535, 0));
        directed.push_back(make_row(CMD_SPEED, 0, 0, 0, 0, 16'h5AA5, 0, 0, 0));
        directed.push_back(make_row(CMD_LOAD, 0, 800, 1000, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_LOAD, 63, 1600, -1000, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 800, 0, 1, 1000, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 1200, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 1201, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_LOAD, 1, 800, 5, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 800, 0, 1, 5, 0));
        directed.push_back(make_row(CMD_LOAD, 2, 2400, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_LOAD, 3, 3200, 32'h8000_0000, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 2401, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 3199, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_LOAD, 4, 32000, 123, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 32000, 0, 1, 123, 0));
        // Ceiling lies past the wavelength range
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 32767, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 5000, 0, 1, 0, 1));
        directed.push_back(make_row(CMD_UNUSED, 63, 32767, -1, 32767, 65535, 0, 0, 0));
        // Overwrite removes the 1600 grid point
        directed.push_back(make_row(CMD_LOAD, 63, 32767, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 1600, 0, 1, 0, 1));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 1000, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_LOAD, 42, 0, -1, 0, 0, 0, 0, 0));
        directed.push_back(make_row(CMD_SETWL, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            offer_command(directed[i]);

        while (random_items < RANDOM_ITEMS)
        begin
            // Halfway through, let the block drain completely
            if (!paused && random_items == RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (frame_bytes_due.size() != 0)
                    @(posedge clk);
            end
            c = draw_command();
            offer_command(c);
            if (c.op != CMD_UNUSED)
                random_items++;
        end
        in_valid <= 1'b0;

        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d position frames (%0d with a missing grid point),",
                 accepted_count, position_frames, missing_frames);
        $display("%0d speed frames, %0d frame bytes compared.", speed_frames, bytes_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Frame receiver with random stalls and one long hold-off
    initial
    begin : frame_sink
        int          hold;
        frame_byte_t fb;
        @(posedge rst_n);
        forever
        begin
            hold = (((bytes_checked / 200) % 3) == 1) ? 0 : $urandom_range(0, 15);
            if (bytes_checked == 400)
                hold = SINK_HOLD;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            bytes_checked++;
            if (frame_bytes_due.size() == 0)
            begin
                $error("frame_byte %h arrived with no transaction pending", frame_byte);
                mismatch_count++;
            end
            else
            begin
                fb = frame_bytes_due.pop_front();
                if (frame_byte !== fb.data)
                begin
                    $error("frame_byte: expected %h, got %h", fb.data, frame_byte);
                    mismatch_count++;
                end
                if (frame_last !== fb.last)
                begin
                    $error("frame_last: expected %b, got %b", fb.last, frame_last);
                    mismatch_count++;
                end
                if (not_found !== fb.nf)
                begin
                    $error("not_found: expected %b, got %b", fb.nf, not_found);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
